// File: rtl/core/esd_pkg.sv
// Package for the escape segment decoder: payload structs, result and phase codes,
// and sizing of the result queue.
// No dependencies.
package esd_pkg;

  localparam int MAX_RESULTS = 4;
  localparam int RES_IDX_W   = $clog2(MAX_RESULTS);
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
  localparam int FIFO_DEPTH  = 8;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

  // Result kinds.
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_SEG  = 2'd1;
  localparam logic [1:0] KIND_LINE = 2'd2;
  localparam logic [1:0] KIND_ERR  = 2'd3;

  // Fault codes.
  localparam logic FAULT_BAD_ESCAPE = 1'b0;
  localparam logic FAULT_BAR        = 1'b1;

  // Escape phases.
  localparam logic [1:0] PH_NORMAL = 2'd0;
  localparam logic [1:0] PH_ESCAPE = 2'd1;
  localparam logic [1:0] PH_OCT1   = 2'd2;
  localparam logic [1:0] PH_OCT2   = 2'd3;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_BAR       = 8'h7C;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_SEVEN     = 8'h37;
  localparam logic [7:0] RE_BYTE      = 8'd13;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       line_end;
  } esd_in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       escaped_newline;
    logic       special_segment;
    logic       fault_code;
    logic       last;
  } esd_out_t;

  // All results produced by one input byte.
  typedef struct packed {
    logic [RES_CNT_W-1:0]                  count;
    esd_out_t [MAX_RESULTS-1:0]            res;
  } esd_group_t;

  function automatic esd_out_t make_result(logic [1:0] kind, logic [7:0] byte_val,
                                           logic nl, logic sp, logic fc);
    esd_out_t r;
    r.kind            = kind;
    r.out_byte        = byte_val;
    r.escaped_newline = nl;
    r.special_segment = sp;
    r.fault_code      = fc;
    r.last            = 1'b0;
    return r;
  endfunction

endpackage

// File: rtl/core/esd_decode.sv
// Escape decoder: line state registers and the per-byte decode that produces
// up to four results for one accepted byte.
// Depends on esd_pkg.
module esd_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  esd_pkg::esd_in_t  in_data,
  input  logic              segment_mode,
  output esd_pkg::esd_group_t group_out
);
  import esd_pkg::*;

  logic [1:0] escape_phase, escape_phase_next;
  logic [8:0] octal_value, octal_value_next;
  logic       in_special, in_special_next;
  logic       segment_nonempty, segment_nonempty_next;
  logic       dropping_line, dropping_line_next;

  always_comb begin
    logic [7:0]           c;
    logic                 eol;
    logic                 consumed;
    logic                 c_octal;
    logic [RES_CNT_W-1:0] n;
    esd_group_t           grp;

    c        = in_data.text_byte;
    eol      = in_data.line_end;
    consumed = 1'b0;
    c_octal  = (c >= CH_ZERO) && (c <= CH_SEVEN);
    n        = '0;
    grp      = '0;

    escape_phase_next     = escape_phase;
    octal_value_next      = octal_value;
    in_special_next       = in_special;
    segment_nonempty_next = segment_nonempty;
    dropping_line_next    = dropping_line;

    if (!dropping_line) begin
      // A pending octal escape either absorbs this byte or is flushed first.
      if (escape_phase == PH_OCT1 || escape_phase == PH_OCT2) begin
        if (c_octal) begin
          octal_value_next = {octal_value[5:0], c[2:0]};
          if (escape_phase == PH_OCT2) begin
            grp.res[n[RES_IDX_W-1:0]] = make_result(KIND_DATA, octal_value_next[7:0],
                                                    1'b0, 1'b0, 1'b0);
            n = n + 1'b1;
            segment_nonempty_next = 1'b1;
            escape_phase_next     = PH_NORMAL;
            octal_value_next      = '0;
          end else begin
            escape_phase_next = PH_OCT2;
          end
          consumed = 1'b1;
        end else begin
          grp.res[n[RES_IDX_W-1:0]] = make_result(KIND_DATA, octal_value[7:0],
                                                  1'b0, 1'b0, 1'b0);
          n = n + 1'b1;
          segment_nonempty_next = 1'b1;
          escape_phase_next     = PH_NORMAL;
          octal_value_next      = '0;
        end
      end

      if (!consumed) begin
        if (escape_phase_next == PH_NORMAL) begin
          if (c == CH_BACKSLASH) begin
            escape_phase_next = PH_ESCAPE;
          end else begin
            grp.res[n[RES_IDX_W-1:0]] = make_result(KIND_DATA, c, 1'b0, 1'b0, 1'b0);
            n = n + 1'b1;
            segment_nonempty_next = 1'b1;
          end
        end else begin
          escape_phase_next = PH_NORMAL;
          if (c == CH_BACKSLASH) begin
            grp.res[n[RES_IDX_W-1:0]] = make_result(KIND_DATA, CH_BACKSLASH,
                                                    1'b0, 1'b0, 1'b0);
            n = n + 1'b1;
            segment_nonempty_next = 1'b1;
          end else if (c == CH_N) begin
            grp.res[n[RES_IDX_W-1:0]] = make_result(KIND_DATA, RE_BYTE, 1'b1, 1'b0, 1'b0);
            n = n + 1'b1;
            segment_nonempty_next = 1'b1;
          end else if (c_octal) begin
            octal_value_next  = {6'd0, c[2:0]};
            escape_phase_next = PH_OCT1;
          end else if (c == CH_BAR && segment_mode) begin
            if (segment_nonempty_next || in_special_next) begin
              grp.res[n[RES_IDX_W-1:0]] = make_result(KIND_SEG, 8'd0, 1'b0,
                                                      in_special_next, 1'b0);
              n = n + 1'b1;
            end
            in_special_next       = ~in_special_next;
            segment_nonempty_next = 1'b0;
          end else begin
            grp.res[n[RES_IDX_W-1:0]] = make_result(KIND_ERR, 8'd0, 1'b0, 1'b0,
                                                    (c == CH_BAR) ? FAULT_BAR
                                                                  : FAULT_BAD_ESCAPE);
            n = n + 1'b1;
            dropping_line_next = 1'b1;
          end
        end
      end

      if (eol && !dropping_line_next) begin
        if (escape_phase_next == PH_ESCAPE) begin
          grp.res[n[RES_IDX_W-1:0]] = make_result(KIND_ERR, 8'd0, 1'b0, 1'b0,
                                                  FAULT_BAD_ESCAPE);
          n = n + 1'b1;
          dropping_line_next = 1'b1;
        end else if (escape_phase_next == PH_OCT1 || escape_phase_next == PH_OCT2) begin
          grp.res[n[RES_IDX_W-1:0]] = make_result(KIND_DATA, octal_value_next[7:0],
                                                  1'b0, 1'b0, 1'b0);
          n = n + 1'b1;
          segment_nonempty_next = 1'b1;
        end
        if (!dropping_line_next && segment_mode &&
            (segment_nonempty_next || in_special_next)) begin
          grp.res[n[RES_IDX_W-1:0]] = make_result(KIND_SEG, 8'd0, 1'b0,
                                                  in_special_next, 1'b0);
          n = n + 1'b1;
        end
      end
    end

    if (eol) begin
      grp.res[n[RES_IDX_W-1:0]] = make_result(KIND_LINE, 8'd0, 1'b0, 1'b0, 1'b0);
      n = n + 1'b1;
      escape_phase_next     = PH_NORMAL;
      octal_value_next      = '0;
      in_special_next       = 1'b0;
      segment_nonempty_next = 1'b0;
      dropping_line_next    = 1'b0;
    end

    if (n != '0) begin
      grp.res[n[RES_IDX_W-1:0] - 1'b1].last = 1'b1;
    end
    grp.count = n;
    group_out = grp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_phase     <= PH_NORMAL;
      octal_value      <= '0;
      in_special       <= 1'b0;
      segment_nonempty <= 1'b0;
      dropping_line    <= 1'b0;
    end else if (accept) begin
      escape_phase     <= escape_phase_next;
      octal_value      <= octal_value_next;
      in_special       <= in_special_next;
      segment_nonempty <= segment_nonempty_next;
      dropping_line    <= dropping_line_next;
    end
  end

endmodule

// File: rtl/core/esd_result_queue.sv
// Result queue: takes a whole group of up to four results in one cycle and
// hands them out one per transaction. Depends on esd_pkg.
module esd_result_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  esd_pkg::esd_group_t group_in,
  output logic                has_room,
  output logic                out_valid,
  input  logic                out_ready,
  output esd_pkg::esd_out_t   out_data
);
  import esd_pkg::*;

  esd_out_t           entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_CW-1:0] count;
  logic [FIFO_CW-1:0] count_next;
  logic [RES_CNT_W-1:0] push_n;
  logic               pop;

  assign push_n    = push ? group_in.count : '0;
  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_data  = entries[rd_ptr];
  // Room for a full group must be guaranteed before a byte is taken.
  assign has_room  = (count <= FIFO_CW'(FIFO_DEPTH - MAX_RESULTS));

  always_comb begin
    count_next = count + FIFO_CW'(push_n) - FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (RES_CNT_W'(i) < push_n) begin
        entries[wr_ptr + FIFO_AW'(i)] <= group_in.res[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

endmodule

// File: rtl/core/escape_segment_decoder_core.sv
// Top level of the escape segment decoder: mode register, decoder and result queue.
// Depends on esd_pkg, esd_decode and esd_result_queue.
//
// Takes one byte of an escaped text line per cycle and emits its decoded results
// (data bytes, segment ends, line done, errors) one per output transaction. A
// byte gives zero to four results; all of them are decoded in the cycle of
// acceptance and written at once into an eight-entry result queue, which drains
// one result per cycle while out_ready is high. Input is taken every cycle while the
// queue holds four results or fewer, so the sustained rate is one byte per cycle
// as long as bytes average at most one result each; bytes that end a line or
// close an octal escape with a second result slow the input only by the extra
// results the output has to drain. The segment_mode register resets to 1 and is
// written through the cfg channel, which is always ready.
module escape_segment_decoder_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  esd_pkg::esd_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output esd_pkg::esd_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);
  import esd_pkg::*;

  logic       segment_mode;
  logic       accept;
  logic       has_room;
  esd_group_t group;

  assign cfg_ready = 1'b1;
  assign in_ready  = has_room;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      segment_mode <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      segment_mode <= cfg_data;
    end
  end

  esd_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .in_data      (in_data),
    .segment_mode (segment_mode),
    .group_out    (group)
  );

  esd_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .group_in  (group),
    .has_room  (has_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
